FILE: sv/ithp_pkg.sv
// Shared types and constants for the IP/transport header parser.
// Used by every module of the parser and by its checker; depends on nothing.
package ithp_pkg;

  localparam int MAX_FRAME_BYTES = 16384;
  localparam int CNT_W = 15;

  localparam logic [15:0] ET_IPV4 = 16'h0800;
  localparam logic [15:0] ET_IPV6 = 16'h86DD;
  localparam logic [7:0] PROTO_TCP = 8'd6;
  localparam logic [7:0] PROTO_UDP = 8'd17;

  localparam logic [CNT_W-1:0] COOKED_HDR_LEN = CNT_W'(16);
  localparam logic [CNT_W-1:0] ETH_HDR_LEN = CNT_W'(14);
  localparam logic [CNT_W-1:0] IPV6_HDR_LEN = CNT_W'(40);
  localparam logic [CNT_W-1:0] UDP_HDR_LEN = CNT_W'(8);

  // link types
  localparam logic [1:0] LINK_COOKED = 2'd0;
  localparam logic [1:0] LINK_ETH = 2'd1;
  localparam logic [1:0] LINK_RAW4 = 2'd2;
  localparam logic [1:0] LINK_RAW6 = 2'd3;

  // parse stages
  localparam logic [1:0] ST_LINK = 2'd0;
  localparam logic [1:0] ST_IP = 2'd1;
  localparam logic [1:0] ST_L4 = 2'd2;
  localparam logic [1:0] ST_FAIL = 2'd3;

  // result status
  localparam logic [2:0] STS_OK = 3'd0;
  localparam logic [2:0] STS_BAD_ETYPE = 3'd1;
  localparam logic [2:0] STS_BAD_L4 = 3'd2;
  localparam logic [2:0] STS_TRUNC = 3'd3;
  localparam logic [2:0] STS_BAD_IHL = 3'd4;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } ithp_in_t;

  typedef struct packed {
    logic [2:0]       status;
    logic             is_ipv6;
    logic [7:0]       proto_id;
    logic [63:0]      src_addr_hi;
    logic [63:0]      src_addr_lo;
    logic [63:0]      dst_addr_hi;
    logic [63:0]      dst_addr_lo;
    logic [15:0]      src_port;
    logic [15:0]      dst_port;
    logic [CNT_W-1:0] payload_pos;
  } ithp_out_t;

  typedef struct packed {
    logic [CNT_W-1:0] byte_count;
    logic [1:0]       stage;
    logic [15:0]      ether_type;
    logic [CNT_W-1:0] l3_start;
    logic [CNT_W-1:0] l4_start;
    logic [CNT_W-1:0] payload_start;
    logic [3:0]       hdr_words;
    logic [7:0]       next_proto;
    logic [127:0]     src_addr;
    logic [127:0]     dst_addr;
    logic [31:0]      ports;
    logic [2:0]       err;
  } ithp_state_t;

endpackage

FILE: sv/ithp_parse.sv
// Per-byte parse step: next frame state and the result for a marked last byte.
// Purely combinational; uses ithp_pkg types and constants.
module ithp_parse (
  input  ithp_pkg::ithp_state_t state_i,
  input  logic [1:0]            link_type,
  input  ithp_pkg::ithp_in_t    in_i,
  output ithp_pkg::ithp_state_t state_o,
  output ithp_pkg::ithp_out_t   res_o
);

  always_comb begin
    ithp_pkg::ithp_state_t           s;
    logic [ithp_pkg::CNT_W-1:0]      p;
    logic [ithp_pkg::CNT_W-1:0]      off;
    logic [ithp_pkg::CNT_W:0]        len;
    logic [7:0]                      b;
    logic                            v6;
    logic                            src_we;
    logic                            dst_we;
    logic                            port_we;
    logic [3:0]                      src_idx;
    logic [3:0]                      dst_idx;
    logic [1:0]                      port_idx;
    logic [2:0]                      status;

    s = state_i;
    p = state_i.byte_count;
    b = in_i.data_byte;
    src_we = 1'b0;
    dst_we = 1'b0;
    port_we = 1'b0;
    src_idx = '0;
    dst_idx = '0;
    port_idx = '0;
    off = '0;

    // first byte: drop the previous frame's state
    if (p == '0) begin
      s = '0;
      s.stage = ithp_pkg::ST_LINK;
      unique case (link_type)
        ithp_pkg::LINK_COOKED: s.l3_start = ithp_pkg::COOKED_HDR_LEN;
        ithp_pkg::LINK_ETH:    s.l3_start = ithp_pkg::ETH_HDR_LEN;
        ithp_pkg::LINK_RAW4:   s.ether_type = ithp_pkg::ET_IPV4;
        ithp_pkg::LINK_RAW6:   s.ether_type = ithp_pkg::ET_IPV6;
        default:               s.ether_type = ithp_pkg::ET_IPV6;
      endcase
    end

    if (s.l3_start != '0) begin
      if (p == s.l3_start - ithp_pkg::CNT_W'(2)) begin
        s.ether_type[15:8] = b;
      end else if (p == s.l3_start - ithp_pkg::CNT_W'(1)) begin
        s.ether_type[7:0] = b;
      end
    end
    v6 = (s.ether_type == ithp_pkg::ET_IPV6);

    if (s.stage == ithp_pkg::ST_LINK && p == s.l3_start) begin
      if (s.ether_type == ithp_pkg::ET_IPV4 || v6) begin
        s.stage = ithp_pkg::ST_IP;
        if (v6) begin
          s.l4_start = s.l3_start + ithp_pkg::IPV6_HDR_LEN;
        end
      end else begin
        s.stage = ithp_pkg::ST_FAIL;
        s.err = ithp_pkg::STS_BAD_ETYPE;
      end
    end

    if (s.stage == ithp_pkg::ST_IP) begin
      off = p - s.l3_start;
      if (!v6) begin
        if (off == '0) begin
          s.hdr_words = b[3:0];
          if (s.hdr_words < 4'd5) begin
            s.stage = ithp_pkg::ST_FAIL;
            s.err = ithp_pkg::STS_BAD_IHL;
          end else begin
            s.l4_start = s.l3_start + ithp_pkg::CNT_W'({s.hdr_words, 2'b00});
          end
        end else if (off == ithp_pkg::CNT_W'(9)) begin
          s.next_proto = b;
        end else if (off >= ithp_pkg::CNT_W'(12) && off < ithp_pkg::CNT_W'(16)) begin
          // IPv4 addresses land in the low 32 bits, wire order
          src_we = 1'b1;
          src_idx = off[3:0];
        end else if (off >= ithp_pkg::CNT_W'(16) && off < ithp_pkg::CNT_W'(20)) begin
          dst_we = 1'b1;
          dst_idx = 4'(off[3:0] - 4'd4);
        end
      end else begin
        if (off == ithp_pkg::CNT_W'(6)) begin
          s.next_proto = b;
        end else if (off >= ithp_pkg::CNT_W'(8) && off < ithp_pkg::CNT_W'(24)) begin
          src_we = 1'b1;
          src_idx = 4'(off[3:0] - 4'd8);
        end else if (off >= ithp_pkg::CNT_W'(24) && off < ithp_pkg::CNT_W'(40)) begin
          dst_we = 1'b1;
          dst_idx = 4'(off[3:0] - 4'd8);
        end
      end
      if (s.stage == ithp_pkg::ST_IP && s.l4_start != '0 && p == s.l4_start) begin
        if (s.next_proto == ithp_pkg::PROTO_UDP) begin
          s.payload_start = s.l4_start + ithp_pkg::UDP_HDR_LEN;
          s.stage = ithp_pkg::ST_L4;
        end else if (s.next_proto == ithp_pkg::PROTO_TCP) begin
          s.stage = ithp_pkg::ST_L4;
        end else begin
          s.stage = ithp_pkg::ST_FAIL;
          s.err = ithp_pkg::STS_BAD_L4;
        end
      end
    end

    if (s.stage == ithp_pkg::ST_L4) begin
      off = p - s.l4_start;
      if (off < ithp_pkg::CNT_W'(4)) begin
        port_we = 1'b1;
        port_idx = off[1:0];
      end else if (off == ithp_pkg::CNT_W'(12) && s.next_proto == ithp_pkg::PROTO_TCP) begin
        s.payload_start = s.l4_start + ithp_pkg::CNT_W'({b[7:4], 2'b00});
      end
    end

    for (int i = 0; i < 16; i++) begin
      if (src_we && src_idx == 4'(i)) begin
        s.src_addr[8*(15-i) +: 8] = s.src_addr[8*(15-i) +: 8] | b;
      end
      if (dst_we && dst_idx == 4'(i)) begin
        s.dst_addr[8*(15-i) +: 8] = s.dst_addr[8*(15-i) +: 8] | b;
      end
    end
    for (int i = 0; i < 4; i++) begin
      if (port_we && port_idx == 2'(i)) begin
        s.ports[8*(3-i) +: 8] = s.ports[8*(3-i) +: 8] | b;
      end
    end

    len = {1'b0, p} + (ithp_pkg::CNT_W+1)'(1);
    if (s.stage == ithp_pkg::ST_FAIL) begin
      status = s.err;
    end else if (s.stage != ithp_pkg::ST_L4 || s.payload_start == '0 ||
                 {1'b0, s.payload_start} >= len) begin
      status = ithp_pkg::STS_TRUNC;
    end else begin
      status = ithp_pkg::STS_OK;
    end

    res_o = '0;
    res_o.status = status;
    if (status == ithp_pkg::STS_OK) begin
      res_o.is_ipv6 = v6;
      res_o.proto_id = s.next_proto;
      res_o.src_addr_hi = s.src_addr[127:64];
      res_o.src_addr_lo = s.src_addr[63:0];
      res_o.dst_addr_hi = s.dst_addr[127:64];
      res_o.dst_addr_lo = s.dst_addr[63:0];
      res_o.src_port = s.ports[31:16];
      res_o.dst_port = s.ports[15:0];
      res_o.payload_pos = s.payload_start;
    end

    // advance the byte counter, saturating on oversize frames; clear it on the last byte
    if (in_i.last_byte) begin
      s.byte_count = '0;
      s.stage = ithp_pkg::ST_LINK;
    end else if (p < ithp_pkg::CNT_W'(ithp_pkg::MAX_FRAME_BYTES - 1)) begin
      s.byte_count = p + ithp_pkg::CNT_W'(1);
    end

    state_o = s;
  end

endmodule

FILE: sv/ithp_out_buf.sv
// Two-entry result buffer: head register plus skid entry.
// Uses ithp_pkg::ithp_out_t.
module ithp_out_buf (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  ithp_pkg::ithp_out_t push_data,
  output logic                can_push,
  output logic                out_valid,
  input  logic                out_ready,
  output ithp_pkg::ithp_out_t out_data
);

  logic                head_v_r;
  logic                head_v_nxt;
  logic                skid_v_r;
  logic                skid_v_nxt;
  ithp_pkg::ithp_out_t head_r;
  ithp_pkg::ithp_out_t head_nxt;
  ithp_pkg::ithp_out_t skid_r;
  ithp_pkg::ithp_out_t skid_nxt;
  logic                pop;

  assign pop = head_v_r && out_ready;
  assign can_push = !skid_v_r;
  assign out_valid = head_v_r;
  assign out_data = head_r;

  // push is only issued while the skid entry is empty
  always_comb begin
    head_v_nxt = head_v_r;
    skid_v_nxt = skid_v_r;
    head_nxt = head_r;
    skid_nxt = skid_r;
    if (push) begin
      if (!head_v_r || pop) begin
        head_nxt = push_data;
        head_v_nxt = 1'b1;
      end else begin
        skid_nxt = push_data;
        skid_v_nxt = 1'b1;
      end
    end else if (pop) begin
      if (skid_v_r) begin
        head_nxt = skid_r;
        skid_v_nxt = 1'b0;
      end else begin
        head_v_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      head_v_r <= head_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    head_r <= head_nxt;
    skid_r <= skid_nxt;
  end

endmodule

FILE: sv/ip_transport_header_parser_unit.sv
// Top level of the IP/transport header parser.
// Instantiates ithp_parse and ithp_out_buf; uses ithp_pkg.
//
// Takes a frame one byte per cycle while in_ready is high, final byte marked,
// and reports one result per frame on that byte: status, address family,
// protocol, addresses, ports and payload offset. Each byte goes through one
// pass of compare-and-capture logic into the frame state registers. Results
// sit in a two-entry buffer; a result shows on out_valid the cycle after its
// last byte if the head entry is free or being read, else it waits in the
// skid entry. in_ready drops only while both entries are held by a stalled
// output. link_type is sampled at each frame's first byte; resets to Ethernet.
module ip_transport_header_parser_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  ithp_pkg::ithp_in_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output ithp_pkg::ithp_out_t out_data,
  input  logic                cfg_wr_en,
  input  logic [1:0]          cfg_wr_data
);

  logic [1:0]            link_type_r;
  ithp_pkg::ithp_state_t state_r;
  ithp_pkg::ithp_state_t state_nxt;
  ithp_pkg::ithp_out_t   res;
  logic                  in_fire;
  logic                  can_push;

  assign in_ready = can_push;
  assign in_fire = in_valid && in_ready;

  ithp_parse u_parse (
    .state_i   (state_r),
    .link_type (link_type_r),
    .in_i      (in_data),
    .state_o   (state_nxt),
    .res_o     (res)
  );

  ithp_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_fire && in_data.last_byte),
    .push_data (res),
    .can_push  (can_push),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      link_type_r <= ithp_pkg::LINK_ETH;
      state_r <= '0;
    end else begin
      if (cfg_wr_en) begin
        link_type_r <= cfg_wr_data;
      end
      if (in_fire) begin
        state_r <= state_nxt;
      end
    end
  end

endmodule

FILE: sv/ithp_checker.sv
// Port-level checks for the IP/transport header parser, bound to the top level.
// Uses ithp_pkg constants.
module ithp_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_ready,
  input ithp_pkg::ithp_out_t out_data
);

  // hold a stalled result
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.status <= ithp_pkg::STS_BAD_IHL)
    else $error("status out of range");

  // failed frames carry nothing but the status
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != ithp_pkg::STS_OK |->
      !out_data.is_ipv6 && out_data.proto_id == '0 &&
      out_data.src_addr_hi == '0 && out_data.src_addr_lo == '0 &&
      out_data.dst_addr_hi == '0 && out_data.dst_addr_lo == '0 &&
      out_data.src_port == '0 && out_data.dst_port == '0 &&
      out_data.payload_pos == '0)
    else $error("failed result has nonzero fields");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == ithp_pkg::STS_OK |->
      out_data.payload_pos != '0 &&
      (out_data.proto_id == ithp_pkg::PROTO_TCP ||
       out_data.proto_id == ithp_pkg::PROTO_UDP))
    else $error("good result with bad protocol or offset");

endmodule

bind ip_transport_header_parser_unit ithp_checker u_ithp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

FILE: test/ithp_frame_checker.sv
// Checker for the IP/transport header parser: watches both channels and the
// config port, predicts each frame's result and compares it field by field.
// Depends on ithp_pkg.
module ithp_frame_checker
  import ithp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_ready,
  input  ithp_in_t   in_data,
  input  logic       out_valid,
  input  logic       out_ready,
  input  ithp_out_t  out_data,
  input  logic       cfg_wr_en,
  input  logic [1:0] cfg_wr_data,
  output int         fail_count,
  output int         results_due
);
  timeunit 1ns;
  timeprecision 1ps;

  // predicted parser state
  logic [1:0]   link_sel;
  int unsigned  pos;
  logic [1:0]   stage;
  logic [15:0]  etype;
  int unsigned  l3_at;
  int unsigned  l4_at;
  int unsigned  pay_at;
  logic [3:0]   ihl;
  logic [7:0]   proto;
  logic [127:0] src_addr;
  logic [127:0] dst_addr;
  logic [31:0]  ports;
  logic [2:0]   err;

  ithp_out_t frame_results_q[$];

  initial begin
    fail_count = 0;
    results_due = 0;
  end

  function automatic void clear_frame();
    stage = ST_LINK;
    etype = '0;
    l3_at = 0;
    l4_at = 0;
    pay_at = 0;
    ihl = '0;
    proto = '0;
    src_addr = '0;
    dst_addr = '0;
    ports = '0;
    err = STS_OK;
  endfunction

  function automatic void abort_frame(input logic [2:0] code);
    err = code;
    stage = ST_FAIL;
  endfunction

  task automatic parse_byte(input logic [7:0] b, input logic last);
    int unsigned off;
    int unsigned len;
    logic v6;
    ithp_out_t res;
    if (pos == 0) begin
      clear_frame();
      case (link_sel)
        LINK_COOKED: l3_at = COOKED_HDR_LEN;
        LINK_ETH:    l3_at = ETH_HDR_LEN;
        LINK_RAW4:   etype = ET_IPV4;
        default:     etype = ET_IPV6;
      endcase
    end

    if (l3_at != 0) begin
      if (pos == l3_at - 2) etype[15:8] = b;
      else if (pos == l3_at - 1) etype[7:0] = b;
    end
    v6 = (etype == ET_IPV6);

    if (stage == ST_LINK && pos == l3_at) begin
      if (etype == ET_IPV4 || v6) begin
        stage = ST_IP;
        if (v6) l4_at = l3_at + IPV6_HDR_LEN;
      end else begin
        abort_frame(STS_BAD_ETYPE);
      end
    end

    if (stage == ST_IP) begin
      off = pos - l3_at;
      if (!v6) begin
        if (off == 0) begin
          ihl = b[3:0];
          if (ihl < 5) abort_frame(STS_BAD_IHL);
          else l4_at = l3_at + ihl * 4;
        end else if (off == 9) begin
          proto = b;
        end else if (off >= 12 && off < 16) begin
          src_addr[8 * (15 - off) +: 8] = b;
        end else if (off >= 16 && off < 20) begin
          dst_addr[8 * (19 - off) +: 8] = b;
        end
      end else begin
        // first wire byte of an address lands in the top byte
        if (off == 6) proto = b;
        else if (off >= 8 && off < 24) src_addr[8 * (15 - (off - 8)) +: 8] = b;
        else if (off >= 24 && off < 40) dst_addr[8 * (15 - (off - 24)) +: 8] = b;
      end
      if (stage == ST_IP && l4_at != 0 && pos == l4_at) begin
        if (proto == PROTO_UDP) begin
          pay_at = l4_at + UDP_HDR_LEN;
          stage = ST_L4;
        end else if (proto == PROTO_TCP) begin
          stage = ST_L4;
        end else begin
          abort_frame(STS_BAD_L4);
        end
      end
    end

    if (stage == ST_L4) begin
      off = pos - l4_at;
      if (off < 4) ports[8 * (3 - off) +: 8] = b;
      else if (off == 12 && proto == PROTO_TCP) pay_at = l4_at + b[7:4] * 4;
    end

    if (!last) begin
      // saturate so an oversized frame reads as the maximum length
      if (pos + 1 < MAX_FRAME_BYTES) pos++;
    end else begin
      len = pos + 1;
      res = '0;
      if (stage == ST_FAIL) begin
        res.status = err;
      end else if (stage != ST_L4 || pay_at == 0 || pay_at >= len) begin
        res.status = STS_TRUNC;
      end else begin
        res.status = STS_OK;
        res.is_ipv6 = v6;
        res.proto_id = proto;
        res.src_addr_hi = src_addr[127:64];
        res.src_addr_lo = src_addr[63:0];
        res.dst_addr_hi = dst_addr[127:64];
        res.dst_addr_lo = dst_addr[63:0];
        res.src_port = ports[31:16];
        res.dst_port = ports[15:0];
        res.payload_pos = CNT_W'(pay_at);
      end
      frame_results_q.push_back(res);
      pos = 0;
      stage = ST_LINK;
    end
  endtask

  task automatic compare_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
      fail_count++;
    end
  endtask

  task automatic check_result(input ithp_out_t got);
    ithp_out_t want;
    if (frame_results_q.size() == 0) begin
      $display("%0t: result with none expected, expected none, actual %p", $time, got);
      fail_count++;
    end else begin
      want = frame_results_q.pop_front();
      compare_field("status", want.status, got.status);
      compare_field("is_ipv6", want.is_ipv6, got.is_ipv6);
      compare_field("proto_id", want.proto_id, got.proto_id);
      compare_field("src_addr_hi", want.src_addr_hi, got.src_addr_hi);
      compare_field("src_addr_lo", want.src_addr_lo, got.src_addr_lo);
      compare_field("dst_addr_hi", want.dst_addr_hi, got.dst_addr_hi);
      compare_field("dst_addr_lo", want.dst_addr_lo, got.dst_addr_lo);
      compare_field("src_port", want.src_port, got.src_port);
      compare_field("dst_port", want.dst_port, got.dst_port);
      compare_field("payload_pos", want.payload_pos, got.payload_pos);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      link_sel = LINK_ETH;
      pos = 0;
      clear_frame();
      frame_results_q.delete();
    end else begin
      if (out_valid && out_ready) check_result(out_data);
      if (in_valid && in_ready) parse_byte(in_data.data_byte, in_data.last_byte);
      if (cfg_wr_en) link_sel = cfg_wr_data;
    end
    results_due = frame_results_q.size();
  end

endmodule

FILE: test/ip_transport_header_parser_unit_test.sv
// Top of the header parser testbench: clock, reset, frame stimulus, flow
// control and the verdict. Uses ithp_pkg, ithp_frame_checker and the parser.
module ip_transport_header_parser_unit_test;
  timeunit 1ns;
  timeprecision 1ps;
  import ithp_pkg::*;

  localparam int FILL_RANDOM = 0;
  localparam int FILL_ZERO = 1;
  localparam int FILL_ONES = 2;
  localparam int QUIET_LIMIT = 5000;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int SETTLE_CYCLES = 4;
  localparam int FRAMES_PER_PHASE = 1;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  ithp_in_t   in_data = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  ithp_out_t  out_data;
  logic       cfg_wr_en = 1'b0;
  logic [1:0] cfg_wr_data = '0;

  int fail_count;
  int results_due;
  int send_idle_pct = 9;
  int recv_idle_pct = 65;
  int hold_req = 0;
  int hold_left = 0;
  int quiet_cycles = 0;
  logic [1:0] cur_link = LINK_ETH;
  logic [7:0] frame_q[$];

  int idle_modes[3][2] = '{'{9, 65}, '{65, 9}, '{0, 0}};
  logic [1:0] link_order[4] = '{LINK_COOKED, LINK_RAW6, LINK_RAW4, LINK_ETH};

  ip_transport_header_parser_unit u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  ithp_frame_checker u_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .fail_count (fail_count),
    .results_due(results_due)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // result side: random stalls, plus a long hold-off on demand
  always @(negedge clk) begin
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  function automatic logic [7:0] filler(input int fill);
    case (fill)
      FILL_ZERO: return 8'h00;
      FILL_ONES: return 8'hff;
      default:   return 8'($urandom);
    endcase
  endfunction

  task automatic build_frame(input logic v6, input logic [15:0] etype, input logic [3:0] ihl,
                             input logic [7:0] proto, input logic [3:0] doff,
                             input int pay_len, input int fill, input int cut);
    int hdr_len;
    int base;
    int n;
    logic [7:0] lo;
    frame_q.delete();
    case (cur_link)
      LINK_COOKED: hdr_len = COOKED_HDR_LEN;
      LINK_ETH:    hdr_len = ETH_HDR_LEN;
      default:     hdr_len = 0;
    endcase
    if (cur_link == LINK_RAW4) v6 = 1'b0;
    if (cur_link == LINK_RAW6) v6 = 1'b1;
    for (int i = 0; i < hdr_len; i++) frame_q.push_back(filler(fill));
    if (hdr_len != 0) begin
      frame_q[hdr_len - 2] = etype[15:8];
      frame_q[hdr_len - 1] = etype[7:0];
    end

    base = frame_q.size();
    if (v6) begin
      for (int i = 0; i < IPV6_HDR_LEN; i++) frame_q.push_back(filler(fill));
      frame_q[base + 6] = proto;
    end else begin
      n = (ihl < 5) ? 20 : ihl * 4;
      for (int i = 0; i < n; i++) frame_q.push_back(filler(fill));
      lo = filler(fill);
      frame_q[base] = {lo[7:4], ihl};
      frame_q[base + 9] = proto;
    end

    base = frame_q.size();
    if (proto == PROTO_TCP) begin
      n = (doff > 5) ? doff * 4 : 20;
      for (int i = 0; i < n; i++) frame_q.push_back(filler(fill));
      lo = filler(fill);
      frame_q[base + 12] = {doff, lo[3:0]};
    end else begin
      for (int i = 0; i < UDP_HDR_LEN; i++) frame_q.push_back(filler(fill));
    end
    for (int i = 0; i < pay_len; i++) frame_q.push_back(filler(fill));
    if (cut > 0 && cut < frame_q.size()) frame_q = frame_q[0:cut - 1];
  endtask

  // mostly well-formed frames with random content; some broken, some noise
  task automatic make_random_frame(input bit tiny);
    logic v6;
    logic [15:0] etype;
    logic [3:0] ihl;
    logic [3:0] doff;
    logic [7:0] proto;
    int pay_len;
    int cut;
    int pick;
    v6 = $urandom_range(1);
    etype = v6 ? ET_IPV6 : ET_IPV4;
    if ($urandom_range(99) < 8) etype = 16'($urandom);
    pick = $urandom_range(99);
    proto = (pick < 45) ? PROTO_UDP : (pick < 90) ? PROTO_TCP : 8'($urandom);
    if ($urandom_range(99) < 10) ihl = 4'($urandom_range(4));
    else ihl = $urandom_range(1) ? 4'd5 : 4'($urandom_range(15, 5));
    doff = ($urandom_range(99) < 12) ? 4'($urandom_range(4)) : 4'($urandom_range(15, 5));
    pay_len = ($urandom_range(9) == 0) ? 0 : $urandom_range(24, 1);
    cut = ($urandom_range(99) < 12) ? $urandom_range(80, 1) : 0;
    if (tiny) cut = $urandom_range(3, 1);
    build_frame(v6, etype, ihl, proto, doff, pay_len, FILL_RANDOM, cut);
    if (!tiny && $urandom_range(99) < 5) begin
      frame_q.delete();
      repeat ($urandom_range(48, 1)) frame_q.push_back(8'($urandom));
    end
  endtask

  task automatic push_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{data_byte: b, last_byte: last};
    // hold the request until the parser takes it
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic send_frame();
    for (int i = 0; i < frame_q.size(); i++) push_byte(frame_q[i], i == frame_q.size() - 1);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (results_due != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  initial begin
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    // directed frames on the reset link type (ethernet)
    build_frame(0, ET_IPV4, 4'd5, PROTO_UDP, 4'd5, 1, FILL_ZERO, 0);
    send_frame();
    build_frame(0, ET_IPV4, 4'd15, PROTO_UDP, 4'd5, 4, FILL_ONES, 0);
    send_frame();
    build_frame(1, ET_IPV6, 4'd5, PROTO_TCP, 4'd15, 3, FILL_ONES, 0);
    send_frame();
    // payload offset equal to frame length
    build_frame(1, ET_IPV6, 4'd5, PROTO_TCP, 4'd5, 0, FILL_ZERO, 0);
    send_frame();
    build_frame(0, 16'h0806, 4'd5, PROTO_UDP, 4'd5, 4, FILL_RANDOM, 0);
    send_frame();
    build_frame(0, ET_IPV4, 4'd5, 8'd1, 4'd5, 4, FILL_RANDOM, 0);
    send_frame();
    build_frame(0, ET_IPV4, 4'd4, PROTO_UDP, 4'd5, 4, FILL_RANDOM, 0);
    send_frame();
    build_frame(0, ET_IPV4, 4'd0, PROTO_UDP, 4'd5, 4, FILL_ONES, 0);
    send_frame();
    // truncated inside the link header, before the ip header, before the
    // transport header and before the tcp data offset byte
    build_frame(0, ET_IPV4, 4'd5, PROTO_UDP, 4'd5, 8, FILL_RANDOM, 1);
    send_frame();
    build_frame(0, ET_IPV4, 4'd5, PROTO_UDP, 4'd5, 8, FILL_RANDOM, 14);
    send_frame();
    build_frame(0, ET_IPV4, 4'd5, PROTO_UDP, 4'd5, 8, FILL_RANDOM, 30);
    send_frame();
    build_frame(0, ET_IPV4, 4'd5, PROTO_TCP, 4'd5, 8, FILL_RANDOM, 46);
    send_frame();
    // short tcp data offsets are taken as given
    build_frame(0, ET_IPV4, 4'd5, PROTO_TCP, 4'd2, 5, FILL_RANDOM, 0);
    send_frame();
    build_frame(1, ET_IPV6, 4'd5, PROTO_TCP, 4'd0, 1, FILL_RANDOM, 0);
    send_frame();

    // stall results long enough to back up the input
    hold_req = HOLD_OFF_CYCLES;
    repeat (12) begin
      make_random_frame(1);
      send_frame();
    end
    settle();

    foreach (idle_modes[m]) begin
      send_idle_pct = idle_modes[m][0];
      recv_idle_pct = idle_modes[m][1];
      foreach (link_order[l]) begin
        settle();
        cur_link = link_order[l];
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= link_order[l];
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        repeat (FRAMES_PER_PHASE) begin
          make_random_frame(0);
          send_frame();
        end
      end
    end

    settle();
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

FILE: sim.f
sv/ithp_pkg.sv
sv/ithp_parse.sv
sv/ithp_out_buf.sv
sv/ip_transport_header_parser_unit.sv
sv/ithp_checker.sv
test/ithp_frame_checker.sv
test/ip_transport_header_parser_unit_test.sv
